@@ design/max_heap_delete_max_unit_assert.svh @@
// Assertion macros shared by the heap unit; empty when synthesized.
`ifndef MAX_HEAP_DELETE_MAX_UNIT_ASSERT_SVH
`define MAX_HEAP_DELETE_MAX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Condition a must hold in the same cycle as b.
`define MHDM_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("heap unit check failed");
// Condition a must be followed by b in the next cycle.
`define MHDM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("heap unit check failed");
`else
`define MHDM_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define MHDM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ design/mhdm_pkg.sv @@
// Shared types, sizes and helpers of the max-heap delete-max unit.
`timescale 1ns / 1ps
package mhdm_pkg;

    // Store size and derived widths.
    localparam int HEAP_DEPTH  = 128;
    localparam int ADDR_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
    localparam int PTR_W       = CNT_W + 1;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    // Operation carried by an input item.
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    // Status returned with each result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Decoded command passed from the front to the back.
    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [7:0]               count_after;
        status_t                  status;
        logic signed [DATA_W-1:0] value;
    } res_t;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } back_stat_t;

    // Low eight bits of an element count.
    function automatic logic [7:0] to_count8(input logic [CNT_W-1:0] c);
        logic [CNT_W+7:0] w;
        w = {8'b0, c};
        return w[7:0];
    endfunction

endpackage

@@ design/mhdm_front.sv @@
// Input stage: accepts items and decodes them into commands.
`timescale 1ns / 1ps
module mhdm_front
    import mhdm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,   // value
    input  logic                s_axis_tuser,   // opcode
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_t                cmd
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    assign s_axis_tready = !hold_valid_reg || cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = hold_valid_reg;
    assign cmd           = cmd_reg;

    // Decode the opcode and keep the item until the queue takes it.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        cmd_next        = cmd_reg;
        if (hold_valid_reg && cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
            unique case (s_axis_tuser)
                1'b0:    cmd_next.op = OP_LOAD;
                default: cmd_next.op = OP_DELETE;
            endcase
            cmd_next.value = s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ design/mhdm_queue.sv @@
// Short command queue between the front and the back.
`timescale 1ns / 1ps
module mhdm_queue
    import mhdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg;
    logic [QP_W-1:0]   wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg;
    logic [QP_W-1:0]   rd_ptr_next;
    logic [QC_W-1:0]   fill_reg;
    logic [QC_W-1:0]   fill_next;
    logic              push;
    logic              pop;

    assign in_ready  = (fill_reg != QC_W'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ design/mhdm_back.sv @@
// Execution back end: heap store, sift-down sequencer and result register.
`timescale 1ns / 1ps
module mhdm_back
    import mhdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res,
    output back_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_SIFT
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [PTR_W-1:0]         parent_reg;
    logic [PTR_W-1:0]         parent_next;
    logic [PTR_W-1:0]         child_reg;
    logic [PTR_W-1:0]         child_next;
    logic signed [DATA_W-1:0] root_reg;
    logic signed [DATA_W-1:0] root_next;
    logic signed [DATA_W-1:0] moved_reg;
    logic signed [DATA_W-1:0] moved_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    res_t                     out_reg;
    res_t                     out_next;

    // Store with two registered read ports and one write port.
    logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    logic                     out_free;
    logic [CNT_W-1:0]         count_inc;
    logic [CNT_W-1:0]         last_idx;
    logic [PTR_W-1:0]         n_ext;
    logic                     take_right;
    logic signed [DATA_W-1:0] sel_val;
    logic [PTR_W-1:0]         sel_pos;
    logic [PTR_W-1:0]         next_child;
    logic [PTR_W-1:0]         next_left_idx;
    logic [PTR_W-1:0]         parent_idx;

    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign stat      = '{busy: (state_reg != S_IDLE), count: count_reg};

    // Helper values for the load, root fetch and sift steps.
    assign count_inc     = count_reg + 1'b1;
    assign last_idx      = count_reg - 1'b1;
    assign n_ext         = {1'b0, count_reg};
    assign take_right    = (child_reg < n_ext) && (rd_a_reg < rd_b_reg);
    assign sel_val       = take_right ? rd_b_reg : rd_a_reg;
    assign sel_pos       = child_reg + PTR_W'(take_right);
    assign next_child    = {sel_pos[PTR_W-2:0], 1'b0};
    assign next_left_idx = next_child - 1'b1;
    assign parent_idx    = parent_reg - 1'b1;

    // Command execution and sift-down sequencing.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        parent_next    = parent_reg;
        child_next     = child_reg;
        root_next      = root_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        addr_a         = '0;
        addr_b         = '0;
        wr_en          = 1'b0;
        wr_addr        = parent_idx[ADDR_W-1:0];
        wr_data        = moved_reg;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    unique case (cmd.op)
                        OP_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == CNT_W'(HEAP_DEPTH))
                            begin
                                out_next = '{count_after: to_count8(count_reg),
                                             status: ST_FULL, value: '0};
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[ADDR_W-1:0];
                                wr_data    = cmd.value;
                                count_next = count_inc;
                                out_next   = '{count_after: to_count8(count_inc),
                                               status: ST_OK, value: '0};
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_next = '{count_after: to_count8(count_reg),
                                             status: ST_EMPTY, value: '0};
                            end
                            else
                            begin
                                // Fetch the root and the last element.
                                addr_a     = '0;
                                addr_b     = last_idx[ADDR_W-1:0];
                                count_next = last_idx;
                                state_next = S_ROOT;
                            end
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                // Latch root and moved value, then fetch both children of the root.
                root_next   = rd_a_reg;
                moved_next  = rd_b_reg;
                parent_next = PTR_W'(1);
                child_next  = PTR_W'(2);
                addr_a      = ADDR_W'(1);
                addr_b      = ADDR_W'(2);
                state_next  = S_SIFT;
            end
            default:
            begin
                if ((child_reg > n_ext) || !(moved_reg < sel_val))
                begin
                    // Moved value settles at the current parent.
                    wr_en          = 1'b1;
                    wr_data        = moved_reg;
                    out_valid_next = 1'b1;
                    out_next       = '{count_after: to_count8(count_reg),
                                       status: ST_OK, value: root_reg};
                    state_next     = S_IDLE;
                end
                else
                begin
                    // Promote the larger child and descend one level.
                    wr_en       = 1'b1;
                    wr_data     = sel_val;
                    parent_next = sel_pos;
                    child_next  = next_child;
                    addr_a      = next_left_idx[ADDR_W-1:0];
                    addr_b      = next_child[ADDR_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            parent_reg    <= '0;
            child_reg     <= '0;
            root_reg      <= '0;
            moved_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            parent_reg    <= parent_next;
            child_reg     <= child_next;
            root_reg      <= root_next;
            moved_reg     <= moved_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Store access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[addr_a];
        rd_b_reg <= heap_mem[addr_b];
    end

endmodule

@@ design/max_heap_delete_max_unit.sv @@
// Top level of the binary max-heap unit with load and delete-max.
//
// Input channel s_axis: tuser carries the opcode (0 = load, 1 = delete max),
// tdata carries the signed 32-bit value, which a delete ignores. Loads append
// in the given order without reordering, so the sender supplies heap order.
// Output channel m_axis: one item per input item, in order. tdata holds the
// removed maximum (zero unless a delete succeeds) and the count after the
// item; tuser holds the status (ok, empty on delete, full on load).
// An input item passes a register stage and a two-entry command queue, so
// the front keeps taking items while the back works or waits on the receiver.
// A load or a refused item is finished in the idle state of the back; a delete
// fetches root and last element, latches them in the root state, then walks one
// heap level per step of the sift state, since each level reads both children and
// writes the parent through the store's two read ports and one write port. A
// load passes the front register, the queue and the back's result register on
// its way to result valid. While the receiver holds tready low the result
// register holds its item and the back takes no new command. Reset empties the
// heap and the queue; the store contents need no clearing.
`timescale 1ns / 1ps
`include "max_heap_delete_max_unit_assert.svh"
module max_heap_delete_max_unit
    import mhdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // value
    input  logic              s_axis_tuser,   // opcode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // result_value, count_after
    output logic [1:0]        m_axis_tuser    // status
);

    logic       f_valid;
    logic       f_ready;
    cmd_t       f_cmd;
    logic       q_valid;
    logic       q_ready;
    cmd_t       q_cmd;
    res_t       res;
    back_stat_t back_stat;

    mhdm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd)
    );

    mhdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    mhdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res),
        .stat      (back_stat)
    );

    assign m_axis_tdata = {res.count_after, res.value};
    assign m_axis_tuser = res.status;

    // The element count never exceeds the store size.
    `MHDM_ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1,
        back_stat.count <= CNT_W'(HEAP_DEPTH))
    // Any result other than a successful delete carries a zero value.
    `MHDM_ASSERT_IMPLIES(a_zero_value, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[31:0] == '0)
    // A refused load only happens with a full store.
    `MHDM_ASSERT_IMPLIES(a_full_count, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == ST_FULL),
        back_stat.count == CNT_W'(HEAP_DEPTH))
    // An empty status only happens with an empty heap.
    `MHDM_ASSERT_IMPLIES(a_empty_count, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY), back_stat.count == '0)

endmodule

@@ sim/heap_extract_checker.sv @@
// Checker that predicts every result item of the max-heap unit and compares it field by field.
`timescale 1ns / 1ps
module heap_extract_checker
    import mhdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // value
    input  logic              s_axis_tuser,   // opcode
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [39:0]       m_axis_tdata,   // result_value, count_after
    input  logic [1:0]        m_axis_tuser,   // status
    output int                error_count,
    output int                pending_count
);

    // Shadow copy of the heap, one-based; the block's store is zero-based.
    logic signed [DATA_W-1:0] heap_mem [1:HEAP_DEPTH];
    int unsigned              heap_fill = 0;

    // Results still owed by the block, oldest first.
    res_t expected_results [$];
    int   waiting     = 0;
    int   fail_total  = 0;
    int   result_seen = 0;

    assign error_count   = fail_total;
    assign pending_count = waiting;

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_total++;
    endtask

    // Apply one item to the shadow heap and return the result it causes.
    function automatic res_t apply_heap_item(input op_t op, input logic signed [DATA_W-1:0] v);
        res_t                     r;
        int unsigned              parent;
        int unsigned              child;
        logic signed [DATA_W-1:0] moved;
        r.value  = '0;
        r.status = ST_OK;
        if (op == OP_LOAD)
        begin
            if (heap_fill >= HEAP_DEPTH)
                r.status = ST_FULL;
            else
            begin
                heap_fill++;
                heap_mem[heap_fill] = v;
            end
        end
        else if (heap_fill == 0)
            r.status = ST_EMPTY;
        else
        begin
            // Take the root, move the last element up and sift it down.
            moved   = heap_mem[heap_fill];
            r.value = heap_mem[1];
            heap_fill--;
            parent = 1;
            child  = 2;
            while (child <= heap_fill)
            begin
                // The left child wins a tie between the two children.
                if (child < heap_fill && heap_mem[child] < heap_mem[child + 1])
                    child++;
                if (!(moved < heap_mem[child]))
                    break;
                heap_mem[parent] = heap_mem[child];
                parent = child;
                child  = 2 * parent;
            end
            heap_mem[parent] = moved;
        end
        r.count_after = 8'(heap_fill);
        return r;
    endfunction

    // Predict on every accepted input item and check every accepted result item.
    always @(posedge clk)
    begin : watch
        res_t                     want;
        logic signed [DATA_W-1:0] got_value;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(apply_heap_item(op_t'(s_axis_tuser), s_axis_tdata));
                waiting++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_value = m_axis_tdata[31:0];
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result item: value %0d status %0d count %0d",
                        got_value, m_axis_tuser, m_axis_tdata[39:32]));
                else
                begin
                    want = expected_results.pop_front();
                    waiting--;
                    if (got_value !== want.value)
                        report_mismatch($sformatf("result %0d value: got %0d, expected %0d",
                            result_seen, got_value, want.value));
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                            result_seen, m_axis_tuser, want.status));
                    if (m_axis_tdata[39:32] !== want.count_after)
                        report_mismatch($sformatf("result %0d count: got %0d, expected %0d",
                            result_seen, m_axis_tdata[39:32], want.count_after));
                end
                result_seen++;
            end
        end
    end

endmodule

@@ sim/max_heap_delete_max_unit_test.sv @@
// Testbench top for the max-heap unit: clock, reset, load and delete traffic, and the verdict.
`timescale 1ns / 1ps
module max_heap_delete_max_unit_test;
    import mhdm_pkg::*;

    localparam int RANDOM_ITEMS     = 600;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 32;
    localparam int CYCLE_LIMIT      = 500000;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;     // value
    logic              s_axis_tuser  = OP_LOAD; // opcode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;           // result_value, count_after
    logic [1:0]        m_axis_tuser;           // status

    int error_count;
    int pending_count;

    // Traffic shaping shared between the sender and the receiver.
    int send_idle_pct = 22;
    int recv_idle_pct = 81;
    int send_calm     = 0;
    int recv_calm     = 0;
    bit long_hold_req = 1'b0;

    // Element count as the sender sees it, used only to plan sequences.
    int heap_level = 0;
    int items_sent = 0;
    int cycle_count = 0;

    max_heap_delete_max_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    heap_extract_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result receiver: random back-pressure, calm stretches and one long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (recv_calm > 0)
            begin
                recv_calm--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 99) == 0)
                    recv_calm = 40;
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one item after a random gap and wait until the block takes it.
    task automatic send_item(input op_t op, input logic [DATA_W-1:0] v);
        while (send_calm == 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 29) == 0)
            send_calm = 20;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            if (heap_level < HEAP_DEPTH)
                heap_level++;
        end
        else if (heap_level > 0)
            heap_level--;
        items_sent++;
    endtask

    // Empty the heap, load n values in heap order, then delete some or all of them.
    task automatic run_heap_sequence(input int n);
        longint                   node [1:HEAP_DEPTH];
        logic signed [DATA_W-1:0] root;
        int unsigned              span;
        int                       deletes;
        while (heap_level > 0)
            send_item(OP_DELETE, $urandom);
        // The spread between parent and child decides how many ties appear.
        case ($urandom_range(0, 4))
            0:       span = 0;
            1:       span = 2;
            2:       span = 1000;
            3:       span = 32'h0010_0000;
            default: span = 32'hFFFF_FFFF;
        endcase
        root = ($urandom_range(0, 4) == 0) ? 32'sh7FFF_FFFF : $urandom;
        node[1] = root;
        for (int i = 2; i <= n; i++)
        begin
            node[i] = node[i / 2] - longint'($urandom_range(0, span));
            if (node[i] < -64'sd2147483648)
                node[i] = -64'sd2147483648;
        end
        for (int i = 1; i <= n; i++)
            send_item(OP_LOAD, node[i][31:0]);
        // A full store refuses further loads.
        if (n == HEAP_DEPTH)
            repeat (2) send_item(OP_LOAD, $urandom);
        if ($urandom_range(0, 3) == 0)
            deletes = n - $urandom_range(0, n);
        else
            deletes = n + $urandom_range(0, 2);
        repeat (deletes) send_item(OP_DELETE, $urandom);
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        int random_start;
        int size_pick;
        bit hold_done;
        hold_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty heap, extremes, a tie between children, last element.
        send_item(OP_DELETE, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 32'h7FFF_FFFF);
        send_item(OP_DELETE, 32'h0000_0000);
        send_item(OP_DELETE, 32'h0000_0000);
        send_item(OP_LOAD, 32'd9);
        send_item(OP_LOAD, 32'd7);
        send_item(OP_LOAD, 32'd7);
        send_item(OP_LOAD, 32'd3);
        repeat (4) send_item(OP_DELETE, 32'h5555_5555);
        send_item(OP_LOAD, 32'h0000_0000);
        send_item(OP_LOAD, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 32'h8000_0000);
        send_item(OP_LOAD, 32'h8000_0000);
        repeat (5) send_item(OP_DELETE, 32'hAAAA_AAAA);

        // Random: mostly well-formed heaps, some noise; a full store comes first.
        random_start = items_sent;
        run_heap_sequence(HEAP_DEPTH);
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (items_sent - random_start >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!hold_done)
                begin
                    long_hold_req = 1'b1;
                    hold_done     = 1'b1;
                end
            end
            else if (items_sent - random_start >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 22;
            end
            if ($urandom_range(0, 99) < 70)
            begin
                size_pick = $urandom_range(0, 99);
                if (size_pick < 3)
                    run_heap_sequence(HEAP_DEPTH);
                else if (size_pick < 20)
                    run_heap_sequence($urandom_range(16, 60));
                else
                    run_heap_sequence($urandom_range(1, 15));
            end
            else
                repeat ($urandom_range(1, 8)) send_item(op_t'($urandom_range(0, 1)), $urandom);
        end
        s_axis_tvalid <= 1'b0;

        // Let the checker record the last accepted item before counting what is owed.
        @(posedge clk);

        // Wait for every owed result, then a little longer for strays.
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
